// File: rtl/rc4_pkg.sv
// package: shared constants, opcodes and state codes of the rc4 stream cipher
package rc4_pkg;

  localparam int unsigned KeyStoreDepthDefault = 256;
  localparam int unsigned PermDepth            = 256;
  localparam int unsigned DataW                = 8;
  localparam int unsigned LenW                 = 9;
  localparam int unsigned OpW                  = 2;
  localparam int unsigned LenReset             = 16;

  typedef enum logic [OpW-1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_CIPHER   = 2'd2
  } opcode_e;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_INIT = 11'b000_0000_0010,
    ST_KA   = 11'b000_0000_0100,
    ST_KB   = 11'b000_0000_1000,
    ST_KC   = 11'b000_0001_0000,
    ST_KD   = 11'b000_0010_0000,
    ST_RJ   = 11'b000_0100_0000,
    ST_WI   = 11'b000_1000_0000,
    ST_WJ   = 11'b001_0000_0000,
    ST_KS   = 11'b010_0000_0000,
    ST_PASS = 11'b100_0000_0000
  } state_e;

endpackage

// File: rtl/rc4_if.sv
// interfaces: request, result and configuration channels of the rc4 stream cipher
interface rc4_in_if import rc4_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [DataW-1:0] key_index;
  logic [DataW-1:0] key_byte;
  logic [DataW-1:0] data_in;

  modport source (output valid, output opcode, output key_index, output key_byte,
                  output data_in, input ready);
  modport sink   (input valid, input opcode, input key_index, input key_byte,
                  input data_in, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_out;
  logic             keyed;

  modport source (output valid, output data_out, output keyed, input ready);
  modport sink   (input valid, input data_out, input keyed, output ready);
endinterface

interface rc4_cfg_if import rc4_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LenW-1:0] key_length;

  modport source (output valid, output key_length, input ready);
  modport sink   (input valid, input key_length, output ready);
endinterface

// File: rtl/rc4_stream_cipher.sv
// top level: rc4 stream cipher with key store, permutation memory and output register
//
// A key-load request writes the key store directly. A schedule request first fills
// the permutation memory with the identity, then steps through each entry (read S[k]
// and the key byte, read S[j], write back both entries), all through the one write and
// one read port of the permutation memory. A data request, when keyed, steps through
// accept, read S[i], read S[j], write S[i], write S[j] with the keystream read; when not
// keyed it passes the byte on to the output register unchanged.
// The result sits in an output register, so the next request is taken while it waits;
// a data request only stalls in its last cycle if the previous result is still held.
// key_length is written through its own channel, which is always ready.
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int unsigned KEY_STORE_DEPTH = KeyStoreDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rc4_in_if.sink          in_i,
  rc4_out_if.source       out_o,
  rc4_cfg_if.sink         cfg_i
);

  localparam int unsigned KeyAw  = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
  localparam logic [LenW-1:0] DepthLen = LenW'(KEY_STORE_DEPTH);
  localparam logic [DataW-1:0] LastIdx = DataW'(PermDepth - 1);

  state_e            state_q, state_d;
  logic [DataW-1:0]  i_q, i_d;
  logic [DataW-1:0]  j_q, j_d;
  logic [DataW-1:0]  si_q, si_d;
  logic [DataW-1:0]  sj_q, sj_d;
  logic [DataW-1:0]  data_q, data_d;
  logic [KeyAw-1:0]  pos_q, pos_d;
  logic              keyed_q, keyed_d;
  logic [LenW-1:0]   key_length_q;

  logic              out_valid_q;
  logic [DataW-1:0]  out_data_q;
  logic              out_keyed_q;
  logic              out_load;
  logic [DataW-1:0]  out_data_d;
  logic              out_keyed_d;
  logic              out_free;

  logic              in_acc;
  logic [LenW-1:0]   len_eff;
  logic [LenW-1:0]   pos_inc;
  logic [KeyAw-1:0]  pos_wrap;

  logic              p_we, p_re;
  logic [DataW-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;
  logic              k_we, k_re;
  logic [DataW-1:0]  k_rdata;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    len_eff = key_length_q;
    if (key_length_q == '0) begin
      len_eff = LenW'(1);
    end else if (key_length_q > DepthLen) begin
      len_eff = DepthLen;
    end
  end

  assign pos_inc  = LenW'(pos_q) + LenW'(1);
  assign pos_wrap = (pos_inc >= len_eff) ? '0 : pos_inc[KeyAw-1:0];

  assign k_we = in_acc && (opcode_e'(in_i.opcode) == OP_LOAD_KEY)
                && (LenW'(in_i.key_index) < DepthLen);
  assign k_re = (state_q == ST_KA);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    data_d      = data_q;
    pos_d       = pos_q;
    keyed_d     = keyed_q;
    p_we        = 1'b0;
    p_waddr     = i_q;
    p_wdata     = si_q;
    p_re        = 1'b0;
    p_raddr     = i_q;
    out_load    = 1'b0;
    out_data_d  = data_q;
    out_keyed_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_e'(in_i.opcode))
            OP_SCHEDULE: begin
              state_d = ST_INIT;
              i_d     = '0;
            end
            OP_CIPHER: begin
              data_d = in_i.data_in;
              if (keyed_q) begin
                i_d     = i_q + DataW'(1);
                p_re    = 1'b1;
                p_raddr = i_q + DataW'(1);
                state_d = ST_RJ;
              end else begin
                state_d = ST_PASS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INIT: begin
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = i_q;
        i_d     = i_q + DataW'(1);
        if (i_q == LastIdx) begin
          j_d     = '0;
          pos_d   = '0;
          state_d = ST_KA;
        end
      end
      ST_KA: begin
        p_re    = 1'b1;
        p_raddr = i_q;
        state_d = ST_KB;
      end
      ST_KB: begin
        si_d    = p_rdata;
        j_d     = j_q + p_rdata + k_rdata;
        p_re    = 1'b1;
        p_raddr = j_q + p_rdata + k_rdata;
        state_d = ST_KC;
      end
      ST_KC: begin
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = p_rdata;
        state_d = ST_KD;
      end
      ST_KD: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = si_q;
        i_d     = i_q + DataW'(1);
        pos_d   = pos_wrap;
        if (i_q == LastIdx) begin
          j_d     = '0;
          keyed_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KA;
        end
      end
      ST_RJ: begin
        si_d    = p_rdata;
        j_d     = j_q + p_rdata;
        p_re    = 1'b1;
        p_raddr = j_q + p_rdata;
        state_d = ST_WI;
      end
      ST_WI: begin
        sj_d    = p_rdata;
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = p_rdata;
        state_d = ST_WJ;
      end
      ST_WJ: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = si_q;
        p_re    = 1'b1;
        p_raddr = si_q + sj_q;
        state_d = ST_KS;
      end
      ST_KS: begin
        out_data_d  = data_q ^ p_rdata;
        out_keyed_d = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_PASS: begin
        out_data_d  = data_q;
        out_keyed_d = 1'b0;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      pos_q        <= '0;
      keyed_q      <= 1'b0;
      key_length_q <= LenW'(LenReset);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pos_q   <= pos_d;
      keyed_q <= keyed_d;
      if (cfg_i.valid && cfg_i.ready) begin
        key_length_q <= cfg_i.key_length;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    data_q <= data_d;
    if (out_load) begin
      out_data_q  <= out_data_d;
      out_keyed_q <= out_keyed_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;
  assign out_o.keyed    = out_keyed_q;

  rc4_ram #(
    .WIDTH (DataW),
    .DEPTH (PermDepth)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  rc4_ram #(
    .WIDTH (DataW),
    .DEPTH (KEY_STORE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (in_i.key_index[KeyAw-1:0]),
    .wdata_i (in_i.key_byte),
    .re_i    (k_re),
    .raddr_i (pos_q),
    .rdata_o (k_rdata)
  );

endmodule

// File: rtl/rc4_ram.sv
// generic ram: one write port, one registered read port, write-first on a shared address
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rc4_checker.sv
// checker: port-level assertions of the rc4 stream cipher and its bind
module rc4_checker import rc4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o,
  rc4_cfg_if.sink   cfg_i
);

  logic in_acc;
  assign in_acc = in_i.valid && in_i.ready;

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_o.data_out) && $stable(out_o.keyed))
    else $error("result changed while stalled");

  // schedule and data requests keep the block busy for the next cycle
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((in_i.opcode == OP_SCHEDULE) || (in_i.opcode == OP_CIPHER))
    |=> !in_i.ready)
    else $error("request taken while previous one still in progress");

  // a key-load request never stalls the next one
  a_key_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.opcode == OP_LOAD_KEY) |=> in_i.ready)
    else $error("key load stalled the request channel");

endmodule

bind rc4_stream_cipher rc4_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o),
  .cfg_i  (cfg_i)
);
